// ===== hw/rtl/pbc_pkg.sv =====
`timescale 1ns / 1ps

package pbc_pkg;

  localparam int FRAC_BITS = 14;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int HALF      = 1 << (FRAC_BITS - 1);

  localparam int PIX_W   = 8;
  localparam int NCHAN   = 3;
  localparam int TDATA_W = 4 * PIX_W;
  localparam int CFG_W   = 16;
  localparam int CFG_AW  = 1;
  localparam int NSTAGE  = 6;

  // saturated register value, signed, -ONE..ONE
  localparam int K_W    = FRAC_BITS + 2;
  localparam int KEEP_W = FRAC_BITS + 1;
  localparam int C2_W   = FRAC_BITS + 3;
  localparam int GAIN_W = FRAC_BITS + 5;

  // reciprocal of alpha: ceil(2^(FRAC_BITS+RCP_SHIFT) / max(1, alpha))
  localparam int RCP_SHIFT = 16;
  localparam int RCP_W     = FRAC_BITS + RCP_SHIFT + 1;
  localparam int RCP_N     = 1 << PIX_W;

  localparam int V_W = FRAC_BITS + PIX_W;
  localparam int Q_W = FRAC_BITS + 14;
  localparam int R_W = Q_W + 1;

  typedef enum logic [CFG_AW-1:0] {
    REG_BRIGHTNESS = 1'b0,
    REG_CONTRAST   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [KEEP_W-1:0] keep;
    logic [KEEP_W-1:0] add;
  } coef_t;

endpackage

// ===== hw/rtl/pbc_coef.sv =====
`timescale 1ns / 1ps

module pbc_coef (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [pbc_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [pbc_pkg::CFG_W-1:0]   cfg_data,
  output pbc_pkg::coef_t              coef
);
  import pbc_pkg::*;

  function automatic logic signed [K_W-1:0] sat_unit(input logic [CFG_W-1:0] raw);
    logic signed [31:0] x;
    x = 32'($signed(raw));
    if (x > ONE) begin
      return K_W'(ONE);
    end else if (x < -ONE) begin
      return K_W'(-ONE);
    end
    return K_W'(x);
  endfunction

  logic signed [K_W-1:0]        k;
  logic [C2_W-1:0]              c2;
  logic [GAIN_W-1:0]            c4;
  logic [GAIN_W-1:0]            gain;
  logic [KEEP_W-1:0]            keep;
  logic [KEEP_W-1:0]            add;

  logic signed [K_W-1:0]        sat_val;
  logic [KEEP_W-1:0]            bmag;
  logic [K_W-1:0]               c;
  logic [2*K_W-1:0]             csq;
  logic [2*C2_W-1:0]            c2sq;
  logic [GAIN_W-1:0]            gbase;
  logic [GAIN_W+K_W-2:0]        gprod;
  logic [C2_W-1:0]              c2_next;
  logic [GAIN_W-1:0]            c4_next;
  logic [GAIN_W-1:0]            gain_next;

  always_comb begin
    sat_val   = sat_unit(cfg_data);
    bmag      = sat_val[K_W-1] ? KEEP_W'(-sat_val) : KEEP_W'(sat_val);
    c         = K_W'(ONE) + K_W'(k);
    csq       = c * c;
    c2_next   = C2_W'(csq >> FRAC_BITS);
    c2sq      = c2 * c2;
    c4_next   = GAIN_W'(c2sq >> FRAC_BITS);
    gbase     = GAIN_W'(ONE) + c4;
    gprod     = gbase * k[K_W-2:0];
    // negative contrast: gain is ONE + k, which is c
    gain_next = k[K_W-1] ? GAIN_W'(c) : GAIN_W'(gprod >> FRAC_BITS) + GAIN_W'(ONE);
  end

  // gain chain: k -> c2 -> c4 -> gain, each step registered after a write
  always_ff @(posedge clk) begin
    if (rst) begin
      k    <= '0;
      c2   <= C2_W'(ONE);
      c4   <= GAIN_W'(ONE);
      gain <= GAIN_W'(ONE);
      keep <= KEEP_W'(ONE);
      add  <= '0;
    end else begin
      c2   <= c2_next;
      c4   <= c4_next;
      gain <= gain_next;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_addr))
          REG_BRIGHTNESS: begin
            keep <= KEEP_W'(ONE) - bmag;
            add  <= sat_val[K_W-1] ? '0 : KEEP_W'(sat_val);
          end
          REG_CONTRAST: begin
            k <= sat_val;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign coef.gain = gain;
  assign coef.keep = keep;
  assign coef.add  = add;

endmodule

// ===== hw/rtl/pbc_rcp_rom.sv =====
`timescale 1ns / 1ps

module pbc_rcp_rom (
  input  logic [pbc_pkg::PIX_W-1:0] alpha,
  output logic [pbc_pkg::RCP_W-1:0] rcp
);
  import pbc_pkg::*;

  logic [RCP_W-1:0] tab [RCP_N];

  for (genvar Den = 0; Den < RCP_N; Den++) begin : g_tab
    localparam logic [63:0] Dv = (Den == 0) ? 64'd1 : 64'(Den);
    localparam logic [63:0] Rv = ((64'd1 << (FRAC_BITS + RCP_SHIFT)) + Dv - 64'd1) / Dv;
    assign tab[Den] = RCP_W'(Rv);
  end

  assign rcp = tab[alpha];

endmodule

// ===== hw/rtl/pbc_chan.sv =====
`timescale 1ns / 1ps

module pbc_chan (
  input  logic                        clk,
  input  logic [pbc_pkg::NSTAGE-1:0]  ld,
  input  logic [pbc_pkg::PIX_W-1:0]   color_in,
  input  logic [pbc_pkg::RCP_W-1:0]   rcp1,
  input  logic [pbc_pkg::PIX_W-1:0]   alpha5,
  input  pbc_pkg::coef_t              coef,
  output logic [pbc_pkg::PIX_W-1:0]   color_out
);
  import pbc_pkg::*;

  logic [PIX_W-1:0]                col1;
  logic [V_W-1:0]                  v2;
  logic signed [Q_W-1:0]           q3;
  logic signed [R_W-1:0]           r4;
  logic [KEEP_W-1:0]               w5;
  logic [PIX_W-1:0]                o6;

  logic [RCP_W+PIX_W-1:0]          m2;
  logic signed [V_W:0]             d3;
  logic signed [V_W+GAIN_W+1:0]    p3;
  logic signed [Q_W:0]             t4;
  logic signed [Q_W+KEEP_W+1:0]    p4;
  logic signed [R_W:0]             s5;
  logic [KEEP_W-1:0]               w5_next;
  logic [KEEP_W+PIX_W-1:0]         m6;

  always_comb begin
    m2 = col1 * rcp1;
    d3 = $signed({1'b0, v2}) - $signed((V_W+1)'(HALF));
    p3 = d3 * $signed({1'b0, coef.gain});
    t4 = (Q_W+1)'(q3) + $signed((Q_W+1)'(HALF));
    p4 = t4 * $signed({1'b0, coef.keep});
    s5 = (R_W+1)'(r4) + $signed((R_W+1)'(coef.add));
    if (s5 < 0) begin
      w5_next = '0;
    end else if (s5 > $signed((R_W+1)'(ONE))) begin
      w5_next = KEEP_W'(ONE);
    end else begin
      w5_next = s5[KEEP_W-1:0];
    end
    m6 = w5 * alpha5;
  end

  always_ff @(posedge clk) begin
    if (ld[0]) col1 <= color_in;
    if (ld[1]) v2   <= m2[RCP_SHIFT +: V_W];
    if (ld[2]) q3   <= Q_W'(p3 >>> FRAC_BITS);
    if (ld[3]) r4   <= R_W'(p4 >>> FRAC_BITS);
    if (ld[4]) w5   <= w5_next;
    if (ld[5]) o6   <= m6[FRAC_BITS +: PIX_W];
  end

  assign color_out = o6;

endmodule

// ===== hw/rtl/pixel_brightness_contrast.sv =====
`timescale 1ns / 1ps

// channel   dir  fields (low bit up)
// s_axis    in   tdata: red_in, green_in, blue_in, alpha_in (8 bits each)
// m_axis    out  tdata: red_out, green_out, blue_out, alpha_out (8 bits each)
// cfg       in   cfg_addr 0 brightness, 1 contrast; cfg_data signed 16 bits
//
// Six-stage pipeline, one pixel per clock while the output is not held by backpressure.
// Stages: reciprocal lookup, divide by alpha, contrast, brightness, clamp, alpha scale.
// Per-stage valid bits; a stage loads when empty or when its successor moves,
// so bubbles close up under output backpressure.
// Reset is synchronous; after a contrast write, gain settles through the registered c2 and c4 steps.
module pixel_brightness_contrast (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [pbc_pkg::TDATA_W-1:0]  s_tdata,   // red_in, green_in, blue_in, alpha_in
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [pbc_pkg::TDATA_W-1:0]  m_tdata,   // red_out, green_out, blue_out, alpha_out
  input  logic                         cfg_we,
  input  logic [pbc_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [pbc_pkg::CFG_W-1:0]    cfg_data
);
  import pbc_pkg::*;

  coef_t              coef;
  logic [NSTAGE-1:0]  vld;
  logic [NSTAGE-1:0]  vld_next;
  logic [NSTAGE:0]    rdy;
  logic [NSTAGE-1:0]  ld;
  logic [PIX_W-1:0]   alpha_q [NSTAGE];
  logic [RCP_W-1:0]   rcp;
  logic [RCP_W-1:0]   rcp1;
  logic [PIX_W-1:0]   chan_out [NCHAN];

  pbc_coef u_coef (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .coef     (coef)
  );

  always_comb begin
    rdy[NSTAGE] = m_tready;
    for (int i = NSTAGE - 1; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
    ld[0]       = rdy[0] && s_tvalid;
    vld_next[0] = rdy[0] ? s_tvalid : vld[0];
    for (int i = 1; i < NSTAGE; i++) begin
      ld[i]       = rdy[i] && vld[i-1];
      vld_next[i] = rdy[i] ? vld[i-1] : vld[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  pbc_rcp_rom u_rcp (
    .alpha (s_tdata[3*PIX_W +: PIX_W]),
    .rcp   (rcp)
  );

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      rcp1       <= rcp;
      alpha_q[0] <= s_tdata[3*PIX_W +: PIX_W];
    end
    for (int i = 1; i < NSTAGE; i++) begin
      if (ld[i]) alpha_q[i] <= alpha_q[i-1];
    end
  end

  for (genvar ch = 0; ch < NCHAN; ch++) begin : g_chan
    pbc_chan u_chan (
      .clk       (clk),
      .ld        (ld),
      .color_in  (s_tdata[ch*PIX_W +: PIX_W]),
      .rcp1      (rcp1),
      .alpha5    (alpha_q[NSTAGE-2]),
      .coef      (coef),
      .color_out (chan_out[ch])
    );
  end

  assign s_tready = rdy[0];
  assign m_tvalid = vld[NSTAGE-1];
  assign m_tdata  = {alpha_q[NSTAGE-1], chan_out[2], chan_out[1], chan_out[0]};

endmodule

// ===== hw/rtl/pbc_checker.sv =====
`timescale 1ns / 1ps

module pbc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [pbc_pkg::TDATA_W-1:0]  m_tdata
);
  import pbc_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output transaction changed");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  a_zero_alpha: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3*PIX_W +: PIX_W] == '0 |-> m_tdata[3*PIX_W-1:0] == '0)
    else $error("color nonzero at zero alpha");

  a_premul: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[0 +: PIX_W] <= m_tdata[3*PIX_W +: PIX_W] &&
                 m_tdata[PIX_W +: PIX_W] <= m_tdata[3*PIX_W +: PIX_W] &&
                 m_tdata[2*PIX_W +: PIX_W] <= m_tdata[3*PIX_W +: PIX_W])
    else $error("premultiplied color above alpha");

endmodule

bind pixel_brightness_contrast pbc_checker u_pbc_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import pbc_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] alpha;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } pixel_t;

  localparam int LIMIT       = 600000;
  localparam int SETTLE      = NSTAGE + 4;
  localparam int PHASES      = 11;
  localparam int PHASE_ITEMS = 140;
  localparam int HOLD_CYCLES = 300;

  // Fixed-point pixel adjust predictor plus expected-result queue.
  class pixel_scoreboard;
    logic signed [CFG_W-1:0] brightness;
    logic signed [CFG_W-1:0] contrast;
    longint gain;
    longint keep;
    longint lift;
    pixel_t expected_q[$];
    int errors;

    function new();
      brightness = '0;
      contrast   = '0;
      errors     = 0;
      derive();
    endfunction

    function longint clamp_unit(longint v);
      if (v > ONE) return ONE;
      if (v < -ONE) return -ONE;
      return v;
    endfunction

    function void derive();
      longint k;
      longint b;
      longint c;
      longint c2;
      longint c4;
      k = clamp_unit(longint'(contrast));
      b = clamp_unit(longint'(brightness));
      if (k >= 0) begin
        c    = ONE + k;
        c2   = (c * c) >>> FRAC_BITS;
        c4   = (c2 * c2) >>> FRAC_BITS;
        gain = (((ONE + c4) * k) >>> FRAC_BITS) + ONE;
      end else begin
        gain = ONE + k;
      end
      keep = ONE - ((b < 0) ? -b : b);
      lift = (b >= 0) ? b : 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_BRIGHTNESS: brightness = val;
        REG_CONTRAST:   contrast   = val;
        default: return;
      endcase
      derive();
    endfunction

    function logic [PIX_W-1:0] adjust(logic [PIX_W-1:0] color, logic [PIX_W-1:0] alpha);
      longint div;
      longint v;
      longint t;
      longint w;
      div = (alpha == 0) ? 1 : longint'(alpha);
      v = (longint'(color) << FRAC_BITS) / div;
      t = (((v - HALF) * gain) >>> FRAC_BITS) + HALF;
      w = ((t * keep) >>> FRAC_BITS) + lift;
      if (w < 0) w = 0;
      if (w > ONE) w = ONE;
      return PIX_W'((w * longint'(alpha)) >> FRAC_BITS);
    endfunction

    function void note_pixel(pixel_t p);
      pixel_t e;
      e.red   = adjust(p.red, p.alpha);
      e.green = adjust(p.green, p.alpha);
      e.blue  = adjust(p.blue, p.alpha);
      e.alpha = p.alpha;
      expected_q.push_back(e);
    endfunction

    function void compare_field(string name, logic [PIX_W-1:0] e, logic [PIX_W-1:0] a);
      if (a !== e) begin
        $error("%s mismatch: expected %0d, got %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected output transaction: %h", got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      compare_field("red_out", e.red, got.red);
      compare_field("green_out", e.green, got.green);
      compare_field("blue_out", e.blue, got.blue);
      compare_field("alpha_out", e.alpha, got.alpha);
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [TDATA_W-1:0]  s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic [TDATA_W-1:0]  m_tdata;
  logic                cfg_we;
  logic [CFG_AW-1:0]   cfg_addr;
  logic [CFG_W-1:0]    cfg_data;

  pixel_scoreboard sb;
  int cycles;
  bit rx_steady;
  bit hold_request;

  pixel_brightness_contrast DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) cycles <= cycles + 1;

  function int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function pixel_t rand_pixel();
    pixel_t p;
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) p.alpha = 8'd255;
    else if (r == 4) p.alpha = 8'd0;
    else if (r == 5) p.alpha = 8'd1;
    else p.alpha = PIX_W'($urandom_range(0, 255));
    p.red   = ($urandom_range(0, 3) == 0) ? PIX_W'($urandom_range(0, 255))
                                          : PIX_W'($urandom_range(0, p.alpha));
    p.green = ($urandom_range(0, 3) == 0) ? PIX_W'($urandom_range(0, 255))
                                          : PIX_W'($urandom_range(0, p.alpha));
    p.blue  = ($urandom_range(0, 3) == 0) ? PIX_W'($urandom_range(0, 255))
                                          : PIX_W'($urandom_range(0, p.alpha));
    return p;
  endfunction

  // called at a falling edge; returns at a falling edge with s_tvalid still high
  task automatic send_pixel(pixel_t p, int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= p;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_pixel(p);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int val);
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= CFG_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, CFG_W'(val));
    repeat (SETTLE) @(negedge clk);
  endtask

  function int rand_setting();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 65535);
    return int'($urandom_range(0, 2 * ONE)) - ONE;
  endfunction

  // receiver: random stalls, steady stretches, one long hold on request
  initial begin
    int stall;
    int hold;
    bit hold_done;
    stall = 0;
    hold  = 0;
    hold_done = 1'b0;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        hold = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
        if (!rx_steady && $urandom_range(0, 3) == 0) stall = rand_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_pixel(m_tdata);
  end

  initial begin
    wait (cycles >= LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    pixel_t directed[$];
    int fixed_b[7];
    int fixed_c[7];
    int b;
    int c;
    bit tx_steady;

    sb = new();
    rx_steady    = 1'b0;
    hold_request = 1'b0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    cfg_we   = 1'b0;
    cfg_addr = REG_BRIGHTNESS;
    cfg_data = '0;
    fixed_b = '{ONE, -ONE, ONE, -ONE, 32767, -32768, 0};
    fixed_c = '{ONE, -ONE, -ONE, ONE, -32768, 32767, 0};

    // {alpha, blue, green, red}
    directed = '{
      {8'd0,   8'd0,   8'd0,   8'd0},
      {8'd0,   8'd255, 8'd255, 8'd255},
      {8'd1,   8'd1,   8'd1,   8'd1},
      {8'd1,   8'd255, 8'd0,   8'd255},
      {8'd255, 8'd255, 8'd255, 8'd255},
      {8'd255, 8'd0,   8'd0,   8'd0},
      {8'd255, 8'd32,  8'd64,  8'd128},
      {8'd128, 8'd128, 8'd0,   8'd255},
      {8'd40,  8'd30,  8'd20,  8'd10},
      {8'd100, 8'd50,  8'd100, 8'd200},
      {8'h55,  8'hAA,  8'h55,  8'hAA},
      {8'hAA,  8'h55,  8'hAA,  8'h55},
      {8'd255, 8'd127, 8'd128, 8'd129},
      {8'd2,   8'd1,   8'd2,   8'd3}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (SETTLE) @(negedge clk);

    foreach (directed[i]) send_pixel(directed[i], rand_gap());

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 7) begin
        b = fixed_b[ph];
        c = fixed_c[ph];
      end else begin
        b = rand_setting();
        c = rand_setting();
      end
      write_reg(REG_BRIGHTNESS, b);
      write_reg(REG_CONTRAST, c);
      tx_steady = (ph % 3 == 1);
      rx_steady = (ph % 4 == 3);
      if (ph == 2) begin
        tx_steady = 1'b1;
        hold_request = 1'b1;
      end
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_pixel(rand_pixel(), tx_steady ? 0 : rand_gap());
    end

    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (2 * SETTLE) @(negedge clk);
    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
